// ===== design/bsh64_pkg.sv =====
`timescale 1ns / 1ps

package bsh64_pkg;

  localparam int unsigned MIX_W       = 64;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BLOCK_BYTES = 24;
  localparam int unsigned LANE_BYTES  = 8;
  localparam int unsigned HOLD_W      = 56;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned LANE_SHIFT  = $clog2(LANE_BYTES);
  localparam int unsigned BYTE_IDX_W  = $clog2(LANE_BYTES);
  localparam int unsigned LANE_SEL_W  = 2;

  localparam logic [LANE_SEL_W-1:0] LANE_A = 2'd0;
  localparam logic [LANE_SEL_W-1:0] LANE_B = 2'd1;
  localparam logic [LANE_SEL_W-1:0] LANE_C = 2'd2;

  localparam logic [MIX_W-1:0] GOLDEN     = 64'h9e37_79b9_7f4a_7c13;
  localparam logic [MIX_W-1:0] SEED_RESET = 64'habcd_ef00_1122_3344;

  // one mix is four groups of three rows, one row per cycle
  localparam int unsigned MIX_GROUPS = 4;
  localparam int unsigned MIX_GRP_W  = $clog2(MIX_GROUPS);
  localparam int unsigned SHIFT_A [MIX_GROUPS] = '{43, 38, 35, 12};
  localparam int unsigned SHIFT_B [MIX_GROUPS] = '{9, 23, 49, 18};
  localparam int unsigned SHIFT_C [MIX_GROUPS] = '{8, 5, 11, 22};

  localparam logic [1:0] MIX_PH_A = 2'd0;
  localparam logic [1:0] MIX_PH_B = 2'd1;
  localparam logic [1:0] MIX_PH_C = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MIX_W-1:0]   word_a;
    logic [MIX_W-1:0]   word_b;
    logic [MIX_W-1:0]   word_c;
    logic [MIX_W-1:0]   seed;
    logic [COUNT_W-1:0] count;
    logic               start;
    logic               full;
    logic               key_end;
    logic               is_empty;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADDC,
    BK_MIX,
    BK_EMIT
  } back_state_e;

endpackage

// ===== design/bsh64_if.sv =====
`timescale 1ns / 1ps

interface bsh64_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       key_last;
  logic       key_empty;

  modport source (output valid, key_byte, key_last, key_empty, input ready);
  modport sink   (input valid, key_byte, key_last, key_empty, output ready);
endinterface

interface bsh64_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

interface bsh64_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ===== design/bsh64_front.sv =====
`timescale 1ns / 1ps

module bsh64_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  bsh64_key_if.sink         key_i,
  bsh64_cfg_if.sink         cfg_i,
  output bsh64_pkg::job_t   job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import bsh64_pkg::*;

  logic [MIX_W-1:0]   seed_q, seed_d;
  logic [MIX_W-1:0]   key_seed_q, key_seed_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               start_pend_q, start_pend_d;
  logic [MIX_W-1:0]   word_a_q, word_a_d;
  logic [MIX_W-1:0]   word_b_q, word_b_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;

  logic                  accept;
  logic                  first;
  logic [POS_W-1:0]      p;
  logic [LANE_SEL_W-1:0] lane;
  logic [BYTE_IDX_W-1:0] idx;
  logic                  full;
  logic [COUNT_W-1:0]    count_inc;
  logic [MIX_W-1:0]      na, nb, nc;

  assign cfg_i.ready = 1'b1;
  assign key_i.ready = job_ready_i;
  assign accept      = key_i.valid && key_i.ready;

  always_comb begin
    first     = (count_q == '0);
    p         = first ? '0 : pos_q;
    lane      = LANE_SEL_W'(p >> LANE_SHIFT);
    idx       = BYTE_IDX_W'(p);
    full      = (p == POS_W'(BLOCK_BYTES - 1));
    count_inc = count_q + 1'b1;

    na = first ? '0 : word_a_q;
    nb = first ? '0 : word_b_q;
    nc = first ? '0 : {{(MIX_W - HOLD_W){1'b0}}, hold_q};
    case (lane)
      LANE_A:  na[{idx, 3'b000} +: BYTE_W] = key_i.key_byte;
      LANE_B:  nb[{idx, 3'b000} +: BYTE_W] = key_i.key_byte;
      default: nc[{idx, 3'b000} +: BYTE_W] = key_i.key_byte;
    endcase

    job_o.word_a   = na;
    job_o.word_b   = nb;
    job_o.word_c   = nc;
    job_o.seed     = first ? seed_q : key_seed_q;
    job_o.count    = count_inc;
    job_o.start    = first || start_pend_q;
    job_o.full     = full;
    job_o.key_end  = key_i.key_last;
    job_o.is_empty = key_i.key_empty;
    job_valid_o    = accept && (key_i.key_empty || key_i.key_last || full);

    seed_d       = (cfg_i.valid && cfg_i.ready) ? cfg_i.seed : seed_q;
    key_seed_d   = key_seed_q;
    count_d      = count_q;
    pos_d        = pos_q;
    start_pend_d = start_pend_q;
    word_a_d     = word_a_q;
    word_b_d     = word_b_q;
    hold_d       = hold_q;

    if (accept) begin
      if (key_i.key_empty || key_i.key_last) begin
        count_d      = '0;
        pos_d        = '0;
        start_pend_d = 1'b0;
      end else begin
        count_d    = count_inc;
        key_seed_d = first ? seed_q : key_seed_q;
        if (full) begin
          pos_d        = '0;
          start_pend_d = 1'b0;
          word_a_d     = '0;
          word_b_d     = '0;
          hold_d       = '0;
        end else begin
          pos_d        = p + 1'b1;
          start_pend_d = first || start_pend_q;
          word_a_d     = na;
          word_b_d     = nb;
          hold_d       = nc[HOLD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       <= SEED_RESET;
      count_q      <= '0;
      pos_q        <= '0;
      start_pend_q <= 1'b0;
    end else begin
      seed_q       <= seed_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      start_pend_q <= start_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_seed_q <= key_seed_d;
    word_a_q   <= word_a_d;
    word_b_q   <= word_b_d;
    hold_q     <= hold_d;
  end

endmodule

// ===== design/bsh64_queue.sv =====
`timescale 1ns / 1ps

module bsh64_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsh64_pkg::job_t   push_data_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output bsh64_pkg::job_t   pop_data_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import bsh64_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/bsh64_back.sv =====
`timescale 1ns / 1ps

module bsh64_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsh64_pkg::job_t   job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  bsh64_hash_if.source      hash_o
);
  import bsh64_pkg::*;

  back_state_e          state_q, state_d;
  logic [MIX_W-1:0]     a_q, a_d, b_q, b_d, c_q, c_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;
  logic [MIX_GRP_W-1:0] grp_q, grp_d;
  logic [1:0]           ph_q, ph_d;
  logic                 pend_count_q, pend_count_d;
  logic                 emit_q, emit_d;
  logic                 out_valid_q, out_valid_d;
  logic [MIX_W-1:0]     hash_q, hash_d;

  logic                 slot_free;
  logic                 load_out;
  logic [MIX_W-1:0]     out_val;
  logic [MIX_W-1:0]     a0, b0, c0;
  logic                 last_row;
  logic [MIX_W-1:0]     sh_a [MIX_GROUPS];
  logic [MIX_W-1:0]     sh_b [MIX_GROUPS];
  logic [MIX_W-1:0]     sh_c [MIX_GROUPS];

  assign slot_free         = !out_valid_q || hash_o.ready;
  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = hash_q;

  always_comb begin
    for (int g = 0; g < MIX_GROUPS; g++) begin
      sh_a[g] = c_q >> SHIFT_A[g];
      sh_b[g] = a_q << SHIFT_B[g];
      sh_c[g] = b_q >> SHIFT_C[g];
    end
  end

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    c_d          = c_q;
    cnt_d        = cnt_q;
    grp_d        = grp_q;
    ph_d         = ph_q;
    pend_count_d = pend_count_q;
    emit_d       = emit_q;
    job_ready_o  = 1'b0;
    load_out     = 1'b0;
    out_val      = c_q;
    a0           = job_i.start ? job_i.seed : a_q;
    b0           = job_i.start ? job_i.seed : b_q;
    c0           = job_i.start ? GOLDEN : c_q;
    last_row     = (grp_q == MIX_GRP_W'(MIX_GROUPS - 1)) && (ph_q == MIX_PH_C);

    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          if (job_i.is_empty) begin
            if (slot_free) begin
              job_ready_o = 1'b1;
              load_out    = 1'b1;
              out_val     = '0;
            end
          end else begin
            job_ready_o = 1'b1;
            a_d   = a0 + job_i.word_a;
            b_d   = b0 + job_i.word_b;
            cnt_d = job_i.count;
            grp_d = '0;
            ph_d  = MIX_PH_A;
            if (job_i.full) begin
              c_d          = c0 + job_i.word_c;
              pend_count_d = job_i.key_end;
              emit_d       = 1'b0;
              state_d      = BK_MIX;
            end else begin
              // partial tail: held c bytes go one byte position up
              c_d     = c0 + {job_i.word_c[HOLD_W-1:0], {BYTE_W{1'b0}}};
              state_d = BK_ADDC;
            end
          end
        end
      end
      BK_ADDC: begin
        c_d          = c_q + {{(MIX_W - COUNT_W){1'b0}}, cnt_q};
        pend_count_d = 1'b0;
        emit_d       = 1'b1;
        grp_d        = '0;
        ph_d         = MIX_PH_A;
        state_d      = BK_MIX;
      end
      BK_MIX: begin
        case (ph_q)
          MIX_PH_A: a_d = (a_q - b_q - c_q) ^ sh_a[grp_q];
          MIX_PH_B: b_d = (b_q - c_q - a_q) ^ sh_b[grp_q];
          default:  c_d = (c_q - a_q - b_q) ^ sh_c[grp_q];
        endcase
        if (ph_q == MIX_PH_C) begin
          ph_d  = MIX_PH_A;
          grp_d = grp_q + 1'b1;
        end else begin
          ph_d = ph_q + 1'b1;
        end
        if (last_row) begin
          if (pend_count_q) begin
            state_d = BK_ADDC;
          end else if (emit_q) begin
            state_d = BK_EMIT;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          out_val  = c_q;
          emit_d   = 1'b0;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    out_valid_d = load_out ? 1'b1 : (out_valid_q && !hash_o.ready);
    hash_d      = load_out ? out_val : hash_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      grp_q        <= '0;
      ph_q         <= MIX_PH_A;
      pend_count_q <= 1'b0;
      emit_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      grp_q        <= grp_d;
      ph_q         <= ph_d;
      pend_count_q <= pend_count_d;
      emit_q       <= emit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    cnt_q  <= cnt_d;
    hash_q <= hash_d;
  end

endmodule

// ===== design/byte_stream_hash64_top.sv =====
`timescale 1ns / 1ps

// channel  dir  payload                              word moved
// key_i    in   key_byte[7:0] key_last key_empty     one key byte or an empty-key mark
// cfg_i    in   seed[63:0]                           new seed, always ready
// hash_o   out  hash_value[63:0]                     hash of one finished key
//
// the front takes one key byte per cycle while the queue has room, so long keys stream;
// it packs 24-byte blocks, and a block, a key end or an empty key becomes a job in a
// two-entry queue; the back runs one mix as 12 rows, one row per cycle, and takes a job
// only when idle: a full block is take, 12 rows; a key end is take, count add, 12 rows,
// emit, with its block mixed first when it ends on a block boundary
// rst_ni clears the key state and loads the default seed; no clearing pass is needed
// a stalled hash_o holds its word; key bytes are still taken until the queue fills

module byte_stream_hash64_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsh64_key_if.sink     key_i,
  bsh64_cfg_if.sink     cfg_i,
  bsh64_hash_if.source  hash_o
);
  import bsh64_pkg::*;

  // front to queue
  job_t push_job;
  logic push_valid;
  logic push_ready;

  // queue to back
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  bsh64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_i),
    .cfg_i       (cfg_i),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  bsh64_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  bsh64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .hash_o      (hash_o)
  );

`ifndef SYNTH
  // a key end or an empty key always becomes a job in the same cycle
  a_end_pushes_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_i.valid && key_i.ready && (key_i.key_last || key_i.key_empty) |-> push_valid)
    else $error("key end accepted without a job");

  // the front never offers a job the queue cannot take
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("job pushed into a full queue");

  // an empty-key job gives a zero hash in the next cycle
  a_empty_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready && pop_job.is_empty |=> hash_o.valid && (hash_o.hash_value == '0))
    else $error("empty key did not give a zero hash");
`endif

endmodule

// ===== test/tb_byte_stream_hash64_top.sv =====
`timescale 1ns / 1ps

module tb_byte_stream_hash64_top;
  import bsh64_pkg::*;

  // one word on the key channel
  typedef struct packed {
    logic [7:0] kb;
    logic       last;
    logic       empty;
  } key_word_t;

  // receiver stall patterns, taken in turn from a running cycle counter
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_THIN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_e;

  logic clk;
  logic rst_n;

  bsh64_key_if  key_bus ();
  bsh64_cfg_if  cfg_bus ();
  bsh64_hash_if hash_bus ();

  byte_stream_hash64_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .key_i  (key_bus),
    .cfg_i  (cfg_bus),
    .hash_o (hash_bus)
  );

  // words waiting for the driver, and hashes waiting for the monitor
  key_word_t   pending_words[$];
  logic [63:0] hash_expected[$];
  int          words_queued = 0;
  int          words_taken  = 0;
  int          fail_count   = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;

  // receiver state
  int rx_cycle  = 0;
  int hold_left = 0;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;

  // shadow of the seed register and of the key state
  logic [63:0] seed_shadow;
  logic [63:0] acc_a;
  logic [63:0] acc_b;
  logic [63:0] acc_c;
  logic [63:0] tail_c;   // wide on purpose: the byte at position 23 lands at bits 56..63
  int unsigned blk_pos;
  logic [31:0] key_len;

  // free-running clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // full 12-row mix of the three accumulators
  function automatic void mix_accumulators();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = acc_a;
    b = acc_b;
    c = acc_c;
    a -= b; a -= c; a ^= (c >> 43);
    b -= c; b -= a; b ^= (a << 9);
    c -= a; c -= b; c ^= (b >> 8);
    a -= b; a -= c; a ^= (c >> 38);
    b -= c; b -= a; b ^= (a << 23);
    c -= a; c -= b; c ^= (b >> 5);
    a -= b; a -= c; a ^= (c >> 35);
    b -= c; b -= a; b ^= (a << 49);
    c -= a; c -= b; c ^= (b >> 11);
    a -= b; a -= c; a ^= (c >> 12);
    b -= c; b -= a; b ^= (a << 18);
    c -= a; c -= b; c ^= (b >> 22);
    acc_a = a;
    acc_b = b;
    acc_c = c;
  endfunction

  // back to the state of a fresh key, seeded from the current register
  function automatic void restart_key();
    acc_a   = seed_shadow;
    acc_b   = seed_shadow;
    acc_c   = GOLDEN;
    tail_c  = '0;
    blk_pos = 0;
    key_len = '0;
  endfunction

  // absorb one accepted key word, queueing a hash when the key closes
  function automatic void predict_hash(input key_word_t w);
    logic [63:0] wide;
    wide = {56'd0, w.kb};
    if (w.empty) begin
      // empty key: hash is zero and any partial key is dropped
      restart_key();
      hash_expected.push_back('0);
    end else begin
      if (key_len == '0) restart_key();
      key_len = key_len + 32'd1;
      if (blk_pos < 8)
        acc_a += wide << (8 * blk_pos);
      else if (blk_pos < 16)
        acc_b += wide << (8 * (blk_pos - 8));
      else
        tail_c |= wide << (8 * (blk_pos - 16));
      blk_pos++;
      // a full block is mixed at once, even the one that closes the key
      if (blk_pos >= BLOCK_BYTES) begin
        acc_c  += tail_c;
        tail_c  = '0;
        mix_accumulators();
        blk_pos = 0;
      end
      if (w.last) begin
        acc_c += {32'd0, key_len};
        // held c-lane bytes go in one byte position higher
        acc_c += {tail_c[55:0], 8'd0};
        mix_accumulators();
        hash_expected.push_back(acc_c);
        restart_key();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // key driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : key_driver
    key_word_t w;
    if (!rst_n) begin
      key_bus.valid     <= 1'b0;
      key_bus.key_byte  <= '0;
      key_bus.key_last  <= 1'b0;
      key_bus.key_empty <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      seed_shadow = SEED_RESET;
      restart_key();
    end else begin
      // word taken at this edge: run it through the shadow model
      if (key_bus.valid && key_bus.ready) begin
        predict_hash({key_bus.key_byte, key_bus.key_last, key_bus.key_empty});
        words_taken++;
      end
      // only move on once the offered word has gone
      if (!key_bus.valid || key_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          key_bus.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          key_bus.valid     <= 1'b1;
          key_bus.key_byte  <= w.kb;
          key_bus.key_last  <= w.last;
          key_bus.key_empty <= w.empty;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; a quarter of them run on with no gap at all
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          key_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // hash monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : hash_monitor
    logic [63:0] want;
    rx_mode_e    mode;
    if (!rst_n) begin
      hash_bus.ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
    end else begin
      if (hash_bus.valid && hash_bus.ready) begin
        if (hash_expected.size() == 0) begin
          $error("hash_value: no word expected, actual %h", hash_bus.hash_value);
          fail_count++;
        end else begin
          want = hash_expected.pop_front();
          if (want !== hash_bus.hash_value) begin
            $error("hash_value: expected %h, actual %h", want, hash_bus.hash_value);
            fail_count++;
          end
        end
      end
      rx_cycle++;
      // one long hold-off so that the queue fills and the key input stalls
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 600;
      end
      mode = rx_mode_e'((rx_cycle >> 7) % 4);
      if (hold_left > 0) begin
        hold_left--;
        hash_bus.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   hash_bus.ready <= 1'b1;
          RX_THIN:   hash_bus.ready <= (rx_cycle % 4) != 3;
          RX_COIN:   hash_bus.ready <= 1'($urandom_range(0, 1));
          default:   hash_bus.ready <= (rx_cycle % 5) == 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] kb, input logic last, input logic empty);
    key_word_t w;
    w.kb    = kb;
    w.last  = last;
    w.empty = empty;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // a run of random bytes, closed by a last mark when asked
  task automatic queue_key(input int len, input bit close);
    for (int i = 0; i < len; i++)
      push_word(8'($urandom_range(0, 255)), close && (i == len - 1), 1'b0);
  endtask

  // key length: mostly short, some around the block boundaries, a few long
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      pick_length = $urandom_range(1, 8);
    end else if (r < 8) begin
      pick_length = $urandom_range(9, 30);
    end else if (r == 8) begin
      case ($urandom_range(0, 5))
        0:       pick_length = 23;
        1:       pick_length = 24;
        2:       pick_length = 25;
        3:       pick_length = 47;
        4:       pick_length = 48;
        default: pick_length = 49;
      endcase
    end else begin
      pick_length = $urandom_range(31, 100);
    end
  endfunction

  task automatic fill_random(input int target);
    int made;
    int len;
    int roll;
    made = 0;
    while (made < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        // well-formed key with random content
        len = pick_length();
        queue_key(len, 1'b1);
        made += len;
      end else if (roll < 90) begin
        // empty key, other fields random
        push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        made++;
      end else begin
        // broken key: cut short by an empty mark
        len = $urandom_range(1, 30);
        queue_key(len, 1'b0);
        push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        made += len + 1;
      end
    end
  endtask

  // wait until every word has gone in and every hash has come out, then let the
  // back end settle past its longest mix
  task automatic drain();
    int spin;
    while (words_taken != words_queued) @(posedge clk);
    spin = 0;
    while (hash_expected.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.seed  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    seed_shadow = value;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] seed_plan [5];

    // configuration inputs known from time zero
    cfg_bus.valid     = 1'b0;
    cfg_bus.seed      = '0;
    rst_n             = 1'b0;

    seed_plan[0] = '0;
    seed_plan[1] = '1;
    seed_plan[2] = {$urandom, $urandom};
    seed_plan[3] = 64'h8000_0000_0000_0000;
    seed_plan[4] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the default seed
    push_word(8'hff, 1'b1, 1'b1);           // empty key with the other fields set
    push_word(8'h00, 1'b0, 1'b1);           // empty key, fields clear
    push_word(8'hff, 1'b1, 1'b0);           // one-byte key, top byte value
    push_word(8'h00, 1'b1, 1'b0);           // one-byte key, zero byte
    push_word(8'haa, 1'b0, 1'b0);           // partial key dropped by an empty mark
    push_word(8'h55, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 17; i++)            // reaches the c lane, so the tail shift shows
      push_word(8'hff, i == 16, 1'b0);

    fill_random(360);
    drain();

    // one phase per seed, extremes among them
    for (int p = 0; p < 5; p++) begin
      write_seed(seed_plan[p]);
      if (p == 1) hold_armed = 1'b1;
      fill_random(300);
      drain();
    end

    if (hash_expected.size() != 0) begin
      $error("hash_value: %0d expected words never arrived", hash_expected.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
